### src/lz77td_pkg.sv
// Shared types and constants of the LZ77 triple decoder.
`timescale 1ns / 1ps

package lz77td_pkg;

	localparam int OFFSET_W   = 13;
	localparam int LENGTH_W   = 6;
	localparam int BYTE_W     = 8;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 8;

	localparam int OFFSET_LSB  = 0;
	localparam int LENGTH_LSB  = OFFSET_LSB + OFFSET_W;
	localparam int LITERAL_LSB = LENGTH_LSB + LENGTH_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_LIT
	} state_t;

	// Commands from the sequencer to the pointer unit.
	typedef struct packed {
		logic load;   // a token with a valid copy is taken: start the read pointer
		logic push;   // one byte is written to history this cycle
	} ptr_cmd_t;

endpackage

### src/lz77td_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lz77td_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/lz77td_ptr.sv
// Pointer unit: write position, fill level, copy source pointer and offset check.
`timescale 1ns / 1ps

module lz77td_ptr #(
	parameter int WINDOW_SIZE = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lz77td_pkg::ptr_cmd_t                 cmd,
	input  logic [lz77td_pkg::OFFSET_W-1:0]      back_offset,
	output logic [$clog2(WINDOW_SIZE)-1:0]       wr_addr,
	output logic [$clog2(WINDOW_SIZE)-1:0]       rd_addr,
	output logic [$clog2(WINDOW_SIZE+1)-1:0]     fill,
	output logic                                 offset_bad
);

	localparam int PW = $clog2(WINDOW_SIZE);
	localparam int FW = $clog2(WINDOW_SIZE + 1);
	localparam int AW = ((PW > lz77td_pkg::OFFSET_W) ? PW : lz77td_pkg::OFFSET_W) + 1;

	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [FW-1:0] fill_q;
	logic [AW-1:0] diff;
	logic [AW-1:0] diff_wrap;
	logic [PW-1:0] wp_inc;
	logic [PW-1:0] rp_inc;

	// Source of the first copied byte: write position minus offset, modulo the window.
	always_comb begin
		diff      = AW'(wp_q) - AW'(back_offset);
		diff_wrap = diff[AW-1] ? (diff + AW'(WINDOW_SIZE)) : diff;
	end

	assign wp_inc = (wp_q == PW'(WINDOW_SIZE - 1)) ? '0 : (wp_q + PW'(1));
	assign rp_inc = (rp_q == PW'(WINDOW_SIZE - 1)) ? '0 : (rp_q + PW'(1));

	assign rd_addr    = cmd.load ? diff_wrap[PW-1:0] : rp_inc;
	assign wr_addr    = wp_q;
	assign fill       = fill_q;
	assign offset_bad = (back_offset == '0) || (AW'(back_offset) > AW'(fill_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cmd.push) begin
			wp_q <= wp_inc;
			if (fill_q != FW'(WINDOW_SIZE)) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.push) begin
			rp_q <= rd_addr;
		end
	end

endmodule

### src/lz77_triple_decoder.sv
// Top level of the LZ77 triple decoder: token sequencer, history RAM and output register.
//
//  Channel | Direction | tdata (low bit up)                                | tlast       | tuser
//  --------+-----------+---------------------------------------------------+-------------+-----------
//  s_*     | in        | back_offset[12:0], match_length[18:13],           | -           | -
//          |           | literal_byte[26:19], zero fill [31:27]            |             |
//  m_*     | out       | data_byte[7:0]                                    | last_of_run | bad_offset
//
// A token is worked off in steps: the transfer is taken in ST_IDLE, each copied byte goes
// out in ST_COPY, and the literal follows in ST_LIT. A literal-only token or one with a bad
// offset skips ST_COPY. The copy loop moves one byte per cycle, unless m_tready stalls it,
// through the single write port and single read port of the history RAM.
// Reset clears the write position, the fill level, the sequencer and the output valid; the
// history RAM is not cleared, since the offset check never lets a copy reach an unwritten byte.
// A stall on m_tready holds the output register and freezes the copy loop in place.
`timescale 1ns / 1ps

module lz77_triple_decoder #(
	parameter int WINDOW_SIZE = 4096,
	parameter int MAX_LENGTH  = 63
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lz77td_pkg::S_TDATA_W-1:0]  s_tdata,   // back_offset, match_length, literal_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lz77td_pkg::M_TDATA_W-1:0]  m_tdata,   // data_byte
	output logic                              m_tlast,   // last_of_run
	output logic                              m_tuser    // bad_offset
);

	localparam int PW = $clog2(WINDOW_SIZE);
	localparam int FW = $clog2(WINDOW_SIZE + 1);
	localparam int LW = lz77td_pkg::LENGTH_W;
	localparam int BW = lz77td_pkg::BYTE_W;

	// Unpacked input fields.
	logic [lz77td_pkg::OFFSET_W-1:0] in_offset;
	logic [LW-1:0]                   in_length;
	logic [LW-1:0]                   in_length_sat;
	logic [BW-1:0]                   in_literal;

	assign in_offset  = s_tdata[lz77td_pkg::OFFSET_LSB +: lz77td_pkg::OFFSET_W];
	assign in_length  = s_tdata[lz77td_pkg::LENGTH_LSB +: LW];
	assign in_literal = s_tdata[lz77td_pkg::LITERAL_LSB +: BW];

	// Lengths above the configured maximum are clamped to it.
	assign in_length_sat = (in_length > LW'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : in_length;

	lz77td_pkg::state_t   state_q;
	lz77td_pkg::state_t   state_d;
	lz77td_pkg::ptr_cmd_t ptr_cmd;

	logic          accept;
	logic          copy_ok;
	logic          out_free;
	logic          push;
	logic [BW-1:0] push_byte;
	logic          push_last;
	logic          push_bad;

	logic [PW-1:0] wr_addr;
	logic [PW-1:0] rd_addr;
	logic [FW-1:0] fill;
	logic          offset_bad;
	logic [BW-1:0] rd_data;

	// Token registers held while the token is worked off.
	logic [LW-1:0] cnt_q;
	logic [BW-1:0] lit_q;
	logic          tok_bad_q;
	logic          off_one_q;
	logic [BW-1:0] last_byte_q;

	// Output register.
	logic          out_valid_q;
	logic [BW-1:0] out_data_q;
	logic          out_last_q;
	logic          out_bad_q;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	// A copy runs only for a nonzero length with an offset inside the filled history.
	assign copy_ok  = (in_length_sat != '0) && !offset_bad;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lz77td_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = copy_ok ? lz77td_pkg::ST_COPY : lz77td_pkg::ST_LIT;
				end
			end
			lz77td_pkg::ST_COPY: begin
				if (push && (cnt_q == LW'(1))) begin
					state_d = lz77td_pkg::ST_LIT;
				end
			end
			lz77td_pkg::ST_LIT: begin
				if (push) begin
					state_d = lz77td_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lz77td_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs. An offset of one repeats the byte just written, which the RAM
	// cannot return in time, so that byte is taken from the last-byte register instead.
	always_comb begin
		s_tready     = 1'b0;
		push         = 1'b0;
		push_byte    = lit_q;
		push_last    = 1'b0;
		push_bad     = 1'b0;
		ptr_cmd.load = 1'b0;
		unique case (state_q)
			lz77td_pkg::ST_IDLE: begin
				s_tready     = 1'b1;
				ptr_cmd.load = accept && copy_ok;
			end
			lz77td_pkg::ST_COPY: begin
				push      = out_free;
				push_byte = off_one_q ? last_byte_q : rd_data;
			end
			lz77td_pkg::ST_LIT: begin
				push      = out_free;
				push_byte = lit_q;
				push_last = 1'b1;
				push_bad  = tok_bad_q;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
		ptr_cmd.push = push;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lz77td_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q     <= in_length_sat;
			lit_q     <= in_literal;
			tok_bad_q <= (in_length_sat != '0) && offset_bad;
			off_one_q <= (in_offset == lz77td_pkg::OFFSET_W'(1));
		end else if (push && (state_q == lz77td_pkg::ST_COPY)) begin
			cnt_q <= cnt_q - LW'(1);
		end
		if (push) begin
			last_byte_q <= push_byte;
			out_data_q  <= push_byte;
			out_last_q  <= push_last;
			out_bad_q   <= push_bad;
		end
	end

	lz77td_ptr #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_ptr (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ptr_cmd),
		.back_offset(in_offset),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr),
		.fill       (fill),
		.offset_bad (offset_bad)
	);

	// History window. Every emitted byte is written; the next copy source is read ahead
	// each time a byte goes out.
	lz77td_ram #(
		.WIDTH(BW),
		.DEPTH(WINDOW_SIZE)
	) u_hist (
		.clk  (clk),
		.we   (push),
		.waddr(wr_addr),
		.wdata(push_byte),
		.re   (ptr_cmd.load || ptr_cmd.push),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;

	// A copy in progress always has bytes left to move.
	a_copy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lz77td_pkg::ST_COPY) |-> (cnt_q != '0))
		else $error("copy state entered with no bytes left");

	// A flagged offset only ever rides on the literal, the last byte of a token.
	a_bad_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("bad_offset raised on a copied byte");

	// Once a token is taken, the input stays closed until the token is worked off.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input reopened right after a transfer");

	// The fill level saturates at the window size.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fill <= FW'(WINDOW_SIZE)))
		else $error("history fill level beyond the window");

endmodule
